// ----- hdl/two_link_centroid_kinematics_macros.svh -----
// Assertion macros for the two-link centroid kinematics block.
// Used by the pipeline files; no other dependencies.
`ifndef TWO_LINK_CENTROID_KINEMATICS_MACROS_SVH
`define TWO_LINK_CENTROID_KINEMATICS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TLCK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define TLCK_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TLCK_ASSERT(label, clk, rst, prop)
`define TLCK_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- hdl/tlck_pkg.sv -----
// Shared types and constants for the two-link centroid kinematics block.
// No dependencies.
`default_nettype none
package tlck_pkg;
  localparam int TableLen = 24;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  // configuration register indexes
  localparam logic CfgUpper = 1'b0;
  localparam logic CfgLower = 1'b1;

  typedef struct packed {
    logic [15:0] angle_one;
    logic [15:0] angle_two;
    logic signed [15:0] rate_one;
    logic signed [15:0] rate_two;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] centre_x_one;
    logic signed [31:0] centre_y_one;
    logic signed [31:0] centre_x_two;
    logic signed [31:0] centre_y_two;
    logic signed [31:0] speed_x_one;
    logic signed [31:0] speed_y_one;
    logic signed [31:0] speed_x_two;
    logic signed [31:0] speed_y_two;
  } out_item_t;

  // one rotator's state as it moves down the chain
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

  // per-item data carried beside the rotators
  typedef struct packed {
    logic flip_one;
    logic flip_two;
    logic signed [15:0] rate_one;
    logic signed [15:0] rate_two;
  } side_t;

  localparam logic [31:0] ArcTable [TableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic signed [31:0] round_sat(input logic signed [79:0] v,
                                                   input int s);
    logic signed [79:0] r;
    begin
      r = (v + (80'sd1 <<< (s - 1))) >>> s;
      if (r > 80'sd2147483647) round_sat = 32'sh7fffffff;
      else if (r < -80'sd2147483648) round_sat = 32'sh80000000;
      else round_sat = r[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/tlck_cell.sv -----
// One CORDIC cell: a single micro-rotation for both angles of an item.
// Depends on tlck_pkg.
`default_nettype none
module tlck_cell #(
  parameter int Step = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire tlck_pkg::rot_t  in_one,
  input  wire tlck_pkg::rot_t  in_two,
  input  wire tlck_pkg::side_t in_side,
  output logic                 out_valid,
  output tlck_pkg::rot_t       out_one,
  output tlck_pkg::rot_t       out_two,
  output tlck_pkg::side_t      out_side
);
  localparam logic signed [33:0] Arc = $signed({2'b00, tlck_pkg::ArcTable[Step]});

  function automatic tlck_pkg::rot_t rotate(input tlck_pkg::rot_t r);
    tlck_pkg::rot_t o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    begin
      dx = r.y >>> Step;
      dy = r.x >>> Step;
      if (!r.z[33]) begin
        o.x = r.x - dx;
        o.y = r.y + dy;
        o.z = r.z - Arc;
      end else begin
        o.x = r.x + dx;
        o.y = r.y - dy;
        o.z = r.z + Arc;
      end
      rotate = o;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_one  <= rotate(in_one);
      out_two  <= rotate(in_two);
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/tlck_combine.sv -----
// Output stages: length and rate products, sums, rounding and saturation.
// Depends on tlck_pkg and the macro header.
`include "two_link_centroid_kinematics_macros.svh"
`default_nettype none
module tlck_combine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic signed [33:0] sin_one,
  input  wire logic signed [33:0] cos_one,
  input  wire logic signed [33:0] sin_two,
  input  wire logic signed [33:0] cos_two,
  input  wire tlck_pkg::side_t   in_side,
  input  wire logic [15:0]       len_one,
  input  wire logic [15:0]       len_two,
  output logic                   out_valid,
  output tlck_pkg::out_item_t    out_item
);
  // stage A: length times trig (negate on fold)
  logic va, vb, vc;
  logic signed [50:0] ls1, lc1, ls2, lc2;
  logic signed [15:0] wa1, wa2;
  logic signed [33:0] fs1, fc1, fs2, fc2;
  always_comb begin
    fs1 = in_side.flip_one ? -sin_one : sin_one;
    fc1 = in_side.flip_one ? -cos_one : cos_one;
    fs2 = in_side.flip_two ? -sin_two : sin_two;
    fc2 = in_side.flip_two ? -cos_two : cos_two;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ls1 <= fs1 * $signed({1'b0, len_one});
      lc1 <= fc1 * $signed({1'b0, len_one});
      ls2 <= fs2 * $signed({1'b0, len_two});
      lc2 <= fc2 * $signed({1'b0, len_two});
      wa1 <= in_side.rate_one;
      wa2 <= in_side.rate_two;
    end
  end
  // stage B: rate products; positions summed
  logic signed [67:0] vs1, vc1, vs2, vc2;
  logic signed [52:0] px1, py1, px2, py2;
  always_ff @(posedge clk) begin
    if (en) begin
      vs1 <= ls1 * wa1;
      vc1 <= lc1 * wa1;
      vs2 <= ls2 * wa2;
      vc2 <= lc2 * wa2;
      px1 <= 53'(lc1);
      py1 <= 53'(ls1);
      px2 <= 53'(lc1) * 53'sd2 + 53'(lc2);
      py2 <= 53'(ls1) * 53'sd2 + 53'(ls2);
    end
  end
  // stage C: round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      out_item.centre_x_one <= tlck_pkg::round_sat(80'(px1), 23);
      out_item.centre_y_one <= tlck_pkg::round_sat(80'(py1), 23);
      out_item.centre_x_two <= tlck_pkg::round_sat(80'(px2), 23);
      out_item.centre_y_two <= tlck_pkg::round_sat(80'(py2), 23);
      out_item.speed_x_one  <= tlck_pkg::round_sat(-80'(vs1), 31);
      out_item.speed_y_one  <= tlck_pkg::round_sat(80'(vc1), 31);
      out_item.speed_x_two  <= tlck_pkg::round_sat(-(80'(vs1) * 80'sd2 + 80'(vs2)), 31);
      out_item.speed_y_two  <= tlck_pkg::round_sat(80'(vc1) * 80'sd2 + 80'(vc2), 31);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else if (en) begin
      va <= in_valid; vb <= va; vc <= vb;
    end
  end
  assign out_valid = vc;

  `TLCK_ASSERT(a_valid_moves, clk, rst, en |=> vb == $past(va))
  `TLCK_ASSERT(a_valid_holds, clk, rst, !en |=> vc == $past(vc))
  `TLCK_ASSERT_RST(a_reset_clears, clk, rst |=> !va && !vb && !vc)
endmodule
`default_nettype wire

// ----- hdl/two_link_centroid_kinematics.sv -----
// Throughput: one item per cycle; the CORDIC cell chain and three output
// stages advance together, stalling only when the output item is not taken.
// Reset (synchronous) empties the pipeline and sets both lengths to 1.0 m.
// Depends on tlck_pkg, tlck_cell, tlck_combine and the macro header.
`include "two_link_centroid_kinematics_macros.svh"
`default_nettype none
module two_link_centroid_kinematics #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tlck_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tlck_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data
);
  localparam int N = (CORDIC_STAGES > 24) ? 24 : ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

  logic [15:0] len_one, len_two;
  always_ff @(posedge clk) begin
    if (rst) begin
      len_one <= 16'd256;
      len_two <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        tlck_pkg::CfgUpper: len_one <= cfg_data;
        tlck_pkg::CfgLower: len_two <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance everything unless the output item is stalled
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  function automatic tlck_pkg::rot_t seed(input logic [15:0] a);
    tlck_pkg::rot_t r;
    logic [15:0] w;
    begin
      w = (a[15:14] == 2'b01 || a[15:14] == 2'b10) ? a + 16'h8000 : a;
      r.x = tlck_pkg::GainQ30;
      r.y = '0;
      r.z = $signed({{2{w[15]}}, w, 16'h0000});
      seed = r;
    end
  endfunction

  logic            v   [N+1];
  tlck_pkg::rot_t  r1  [N+1];
  tlck_pkg::rot_t  r2  [N+1];
  tlck_pkg::side_t sd  [N+1];

  always_comb begin
    v[0]  = in_valid;
    r1[0] = seed(in_item.angle_one);
    r2[0] = seed(in_item.angle_two);
    sd[0].flip_one = in_item.angle_one[15] ^ in_item.angle_one[14];
    sd[0].flip_two = in_item.angle_two[15] ^ in_item.angle_two[14];
    sd[0].rate_one = in_item.rate_one;
    sd[0].rate_two = in_item.rate_two;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    tlck_cell #(.Step(i)) u_cell (
      .clk, .rst, .en,
      .in_valid(v[i]), .in_one(r1[i]), .in_two(r2[i]), .in_side(sd[i]),
      .out_valid(v[i+1]), .out_one(r1[i+1]), .out_two(r2[i+1]), .out_side(sd[i+1])
    );
  end

  tlck_combine u_combine (
    .clk, .rst, .en,
    .in_valid(v[N]),
    .sin_one(r1[N].y), .cos_one(r1[N].x),
    .sin_two(r2[N].y), .cos_two(r2[N].x),
    .in_side(sd[N]), .len_one, .len_two,
    .out_valid, .out_item
  );

  `TLCK_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid)
  `TLCK_ASSERT(a_stall_stable, clk, rst, out_valid && !out_ready |=> $stable(out_item))
  `TLCK_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)
endmodule
`default_nettype wire
